>>> hw/rtl/csv_field_splitter_top_defines.svh
// assertion macros for the csv splitter top rtl
// each macro expects clk and rst_n in scope
`ifndef CSV_FIELD_SPLITTER_TOP_DEFINES_SVH
`define CSV_FIELD_SPLITTER_TOP_DEFINES_SVH

// same-cycle implication
`define CSVFS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSVFS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/csvfs_pkg.sv
package csvfs_pkg;

  localparam int MAX_RES = 4;
  localparam int CNT_W   = $clog2(MAX_RES + 1);

  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_UNQ   = 3'd1,
    PH_QUO   = 3'd2,
    PH_QSEEN = 3'd3,
    PH_SKIP  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_BOUND = 2'd1,
    KIND_EOL   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } res_entry_t;

  typedef struct packed {
    res_entry_t [MAX_RES-1:0] ent;
    logic [CNT_W-1:0]         cnt;
  } res_set_t;

endpackage

>>> hw/rtl/csv_field_splitter_top.sv
// csv field splitter: splits one text line, one byte per input transfer,
// into comma-separated fields with doubled-quote escapes in quoted fields.
// input channel: in_valid/in_ready, in_byte and in_end_of_line (high on the
// last byte of a line). result channel: out_valid/out_ready, out_kind
// (0 content byte, 1 field boundary, 2 line end), out_byte (zero unless a
// content byte) and out_run_last (high on the last result of an input byte).
// an input byte gives zero to four results.
// data path: an accepted byte sits in the input stage, is decoded there and is
// loaded into the result buffer once the buffer is free; its first result is
// then offered on out_valid from the result buffer register.
// throughput: one byte per cycle while each byte gives at most one result and
// out_ready stays high; the result port moves one result per cycle while
// out_ready is high, so a byte with several results holds the input side
// until its last result transfers. bytes that give no result pass at full rate.
// reset (rst_n low, synchronous) empties the input stage and result buffer
// and puts the parser at line start with no field open.
// when the receiver stalls, the buffered results hold and the input stage
// keeps one more byte; in_ready drops once both are occupied.
`include "csv_field_splitter_top_defines.svh"

module csv_field_splitter_top
  import csvfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_line,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  // input stage
  logic       s1_v_r;
  logic       s1_v_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_eol_r;

  // parser phase, advanced when a byte leaves the input stage
  phase_t     phase_r;
  phase_t     phase_nxt;
  phase_t     dec_phase;

  res_set_t   dec_set;
  res_entry_t head;
  logic       buf_free;
  logic       load;
  logic       in_fire;

  assign load     = s1_v_r && buf_free;
  assign in_ready = !s1_v_r || load;
  assign in_fire  = in_valid && in_ready;
  assign s1_v_nxt = in_fire || (s1_v_r && !load);
  assign phase_nxt = load ? dec_phase : phase_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      phase_r <= PH_START;
    end else begin
      s1_v_r  <= s1_v_nxt;
      phase_r <= phase_nxt;
    end
  end

  // payload of the input stage needs no reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_byte;
      s1_eol_r  <= in_end_of_line;
    end
  end

  // all results of one byte, worked out in one pass
  csvfs_decode u_decode (
    .phase_i     (phase_r),
    .byte_i      (s1_byte_r),
    .eol_i       (s1_eol_r),
    .set_o       (dec_set),
    .phase_nxt_o (dec_phase)
  );

  // result buffer, drained one transfer per cycle while out_ready is high
  csvfs_out_buf u_out_buf (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (load),
    .set_i       (dec_set),
    .out_ready_i (out_ready),
    .free_o      (buf_free),
    .out_valid_o (out_valid),
    .head_o      (head),
    .last_o      (out_run_last)
  );

  assign out_kind = head.kind;
  assign out_byte = head.data;

  // line end is always the final result of its byte
  `CSVFS_ASSERT_NOW(a_eol_is_last, out_valid && out_kind == KIND_EOL, out_run_last,
    "line end result not marked last")
  // boundaries and line ends carry a zero byte
  `CSVFS_ASSERT_NOW(a_nonbyte_zero, out_valid && out_kind != KIND_BYTE, out_byte == 8'h00,
    "non-content result with nonzero byte")
  // a line end returns the parser to line start
  `CSVFS_ASSERT_NEXT(a_eol_resets_phase, load && s1_eol_r, phase_r == PH_START,
    "phase not at line start after line end")
  // a blocked byte stays in the input stage untouched
  `CSVFS_ASSERT_NEXT(a_stage_holds, s1_v_r && !load, s1_v_r && $stable(s1_byte_r),
    "input stage lost a waiting byte")

endmodule

>>> hw/rtl/csvfs_decode.sv
module csvfs_decode
  import csvfs_pkg::*;
(
  input  phase_t     phase_i,
  input  logic [7:0] byte_i,
  input  logic       eol_i,
  output res_set_t   set_o,
  output phase_t     phase_nxt_o
);

  typedef struct packed {
    logic       emit;
    kind_t      kind;
    logic [7:0] data;
    phase_t     phase;
  } start_res_t;

  // byte seen at field start
  function automatic start_res_t at_start(input logic [7:0] b);
    start_res_t r;
    r.emit  = 1'b1;
    r.kind  = KIND_BOUND;
    r.data  = 8'h00;
    r.phase = PH_START;
    if (b == CH_QUOTE) begin
      r.emit  = 1'b0;
      r.phase = PH_QUO;
    end else if (b == CH_COMMA) begin
      r.phase = PH_START;
    end else if (b == CH_CR || b == CH_LF) begin
      r.phase = PH_SKIP;
    end else begin
      r.kind  = KIND_BYTE;
      r.data  = b;
      r.phase = PH_UNQ;
    end
    return r;
  endfunction

  start_res_t       st;
  res_set_t         set;
  phase_t           ph;
  logic [CNT_W-1:0] n;

  always_comb begin
    set = '0;
    n   = '0;
    ph  = phase_i;
    st  = at_start(byte_i);
    unique case (phase_i)
      PH_UNQ: begin
        if (byte_i == CH_COMMA || byte_i == CH_CR || byte_i == CH_LF) begin
          set.ent[n[1:0]].kind = KIND_BOUND;
          n  = n + 1'b1;
          ph = (byte_i == CH_COMMA) ? PH_START : PH_SKIP;
        end else begin
          set.ent[n[1:0]].kind = KIND_BYTE;
          set.ent[n[1:0]].data = byte_i;
          n = n + 1'b1;
        end
      end
      PH_QUO: begin
        if (byte_i == CH_QUOTE) begin
          ph = PH_QSEEN;
        end else begin
          set.ent[n[1:0]].kind = KIND_BYTE;
          set.ent[n[1:0]].data = byte_i;
          n = n + 1'b1;
        end
      end
      PH_QSEEN: begin
        if (byte_i == CH_QUOTE) begin
          set.ent[n[1:0]].kind = KIND_BYTE;
          set.ent[n[1:0]].data = CH_QUOTE;
          n  = n + 1'b1;
          ph = PH_QUO;
        end else if (byte_i == CH_COMMA) begin
          set.ent[n[1:0]].kind = KIND_BOUND;
          n  = n + 1'b1;
          ph = PH_START;
        end else begin
          // close the quoted field, then treat the byte as a field start
          set.ent[n[1:0]].kind = KIND_BOUND;
          n = n + 1'b1;
          if (st.emit) begin
            set.ent[n[1:0]].kind = st.kind;
            set.ent[n[1:0]].data = st.data;
            n = n + 1'b1;
          end
          ph = st.phase;
        end
      end
      PH_SKIP: begin
        ph = PH_SKIP;
      end
      default: begin
        if (st.emit) begin
          set.ent[n[1:0]].kind = st.kind;
          set.ent[n[1:0]].data = st.data;
          n = n + 1'b1;
        end
        ph = st.phase;
      end
    endcase

    if (eol_i) begin
      if (ph != PH_SKIP) begin
        set.ent[n[1:0]].kind = KIND_BOUND;
        n = n + 1'b1;
      end
      set.ent[n[1:0]].kind = KIND_EOL;
      n  = n + 1'b1;
      ph = PH_START;
    end

    set.cnt     = n;
    set_o       = set;
    phase_nxt_o = ph;
  end

endmodule

>>> hw/rtl/csvfs_out_buf.sv
module csvfs_out_buf
  import csvfs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load_i,
  input  res_set_t   set_i,
  input  logic       out_ready_i,
  output logic       free_o,
  output logic       out_valid_o,
  output res_entry_t head_o,
  output logic       last_o
);

  res_entry_t [MAX_RES-1:0] ent_r;
  logic [CNT_W-1:0]         left_r;
  logic [CNT_W-1:0]         left_nxt;
  logic                     take;

  assign out_valid_o = (left_r != '0);
  assign take        = out_valid_o && out_ready_i;
  assign last_o      = (left_r == CNT_W'(1));
  assign head_o      = ent_r[0];
  // empty now, or last entry leaves this cycle
  assign free_o      = (left_r == '0) || (last_o && out_ready_i);

  always_comb begin
    left_nxt = left_r;
    if (load_i) begin
      left_nxt = set_i.cnt;
    end else if (take) begin
      left_nxt = left_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else begin
      left_r <= left_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      ent_r <= set_i.ent;
    end else if (take) begin
      for (int i = 0; i < MAX_RES - 1; i++) begin
        ent_r[i] <= ent_r[i+1];
      end
    end
  end

endmodule
